[hdl/lav_pkg.sv]
package lav_pkg;

  localparam int UNIT_BITS  = 30;
  localparam int ROOT_STEPS = 31;
  localparam int QUO_STEPS  = 31;
  localparam int NORM_LAT   = 4 + ROOT_STEPS + 1 + QUO_STEPS + 1;

  localparam logic signed [35:0] RND_UMAX = 36'sd1073741823;
  localparam logic signed [35:0] RND_UMIN = -36'sd1073741824;
  localparam logic signed [35:0] RND_SMAX = 36'sd2147483647;
  localparam logic signed [35:0] RND_SMIN = -36'sd2147483648;

  // drop 30 fraction bits, half away from zero
  function automatic logic signed [35:0] round30(input logic signed [64:0] v);
    logic [64:0] mag;
    logic [64:0] sum;
    logic [35:0] m;
    mag = v[64] ? -v : v;
    sum = mag + 65'd536870912;
    m = {1'b0, sum[64:30]};
    return v[64] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [30:0] sat31(input logic signed [35:0] v);
    logic [30:0] r;
    if (v > RND_UMAX) begin
      r = RND_UMAX[30:0];
    end else if (v < RND_UMIN) begin
      r = RND_UMIN[30:0];
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > RND_SMAX) begin
      r = RND_SMAX[31:0];
    end else if (v < RND_SMIN) begin
      r = RND_SMIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/lav_delay.sv]
module lav_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[D-1];

endmodule

[hdl/lav_norm.sv]
module lav_norm #(
  parameter int CW = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][CW-1:0]  vec,
  output logic                out_valid,
  output logic [2:0][30:0]    unit
);

  localparam int LZW = $clog2(CW);
  localparam int NL  = lav_pkg::NORM_LAT;
  localparam int MW  = lav_pkg::UNIT_BITS;
  localparam int RS  = lav_pkg::ROOT_STEPS;
  localparam int QS  = lav_pkg::QUO_STEPS;

  typedef struct packed {
    logic [2:0]          neg;
    logic                zero;
    logic [2:0][MW-1:0]  m;
  } side_t;

  logic [NL-1:0]        vld;
  logic [2:0][CW-1:0]   mag1;
  logic [2:0]           neg1;
  logic [CW-1:0]        orv;
  logic [CW-1:0]        tor;
  logic [2:0][CW-1:0]   shl;
  side_t                sb2;
  side_t                sb3;
  logic [2:0][2*MW-1:0] sq3;

  logic [63:0]          rn      [RS+1];
  logic [63:0]          rr      [RS+1];
  side_t                rsb     [RS+1];
  logic [63:0]          rn_next [RS];
  logic [63:0]          rr_next [RS];
  logic [MW:0]          rt;

  logic [2:0][63:0]     qrem      [QS+1];
  logic [2:0][MW:0]     qq        [QS+1];
  logic [MW:0]          qd        [QS+1];
  side_t                qsb       [QS+1];
  logic [2:0][63:0]     qrem_next [QS];
  logic [2:0][MW:0]     qq_next   [QS];
  logic [63:0]          dvs       [QS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NL-2:0], in_valid};
    end
  end

  assign out_valid = vld[NL-1];

  always_comb begin
    orv = mag1[0] | mag1[1] | mag1[2];
    tor = orv;
    shl = mag1;
    for (int k = LZW - 1; k >= 0; k--) begin
      if ((tor >> (CW - (1 << k))) == '0) begin
        tor = tor << (1 << k);
        for (int i = 0; i < 3; i++) begin
          shl[i] = shl[i] << (1 << k);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < RS; k++) begin
      if (rn[k] >= rr[k] + (64'd1 << (2 * (RS - 1 - k)))) begin
        rn_next[k] = rn[k] - (rr[k] + (64'd1 << (2 * (RS - 1 - k))));
        rr_next[k] = (rr[k] >> 1) + (64'd1 << (2 * (RS - 1 - k)));
      end else begin
        rn_next[k] = rn[k];
        rr_next[k] = rr[k] >> 1;
      end
    end
  end

  assign rt = rr[RS][MW:0];

  always_comb begin
    for (int j = 0; j < QS; j++) begin
      dvs[j] = {{(64-MW-1){1'b0}}, qd[j]} << (QS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (qrem[j][i] >= dvs[j]) begin
          qrem_next[j][i] = qrem[j][i] - dvs[j];
          qq_next[j][i]   = {qq[j][i][MW-1:0], 1'b1};
        end else begin
          qrem_next[j][i] = qrem[j][i];
          qq_next[j][i]   = {qq[j][i][MW-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= vec[i][CW-1] ? -vec[i] : vec[i];
        neg1[i] <= vec[i][CW-1];
        sb2.m[i] <= shl[i][CW-1 -: MW];
        sq3[i] <= sb2.m[i] * sb2.m[i];
      end
      sb2.neg  <= neg1;
      sb2.zero <= (orv == '0);
      sb3      <= sb2;

      rn[0]  <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
      rr[0]  <= '0;
      rsb[0] <= sb3;
      for (int k = 0; k < RS; k++) begin
        rn[k+1]  <= rn_next[k];
        rr[k+1]  <= rr_next[k];
        rsb[k+1] <= rsb[k];
      end

      for (int i = 0; i < 3; i++) begin
        qrem[0][i] <= {4'd0, rsb[RS].m[i], {MW{1'b0}}} + {33'd0, (rt >> 1)};
      end
      qq[0]  <= '0;
      qd[0]  <= rt;
      qsb[0] <= rsb[RS];
      for (int j = 0; j < QS; j++) begin
        qrem[j+1] <= qrem_next[j];
        qq[j+1]   <= qq_next[j];
        qd[j+1]   <= qd[j];
        qsb[j+1]  <= qsb[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (qsb[QS].zero) begin
          unit[i] <= '0;
        end else if (qsb[QS].neg[i]) begin
          unit[i] <= -qq[QS][i];
        end else if (qq[QS][i][MW]) begin
          unit[i] <= {1'b0, {MW{1'b1}}};
        end else begin
          unit[i] <= qq[QS][i];
        end
      end
    end
  end

endmodule

[hdl/lookat_view_matrix_top.sv]
// Channel  Dir  Bits  Contents
// s_*      in   288   eye_x/y/z, target_x/y/z, upward_x/y/z (32 bits each)
// m_*      out  376   side, trueup, back (31 bits each), shift_x/y/z (32 bits)
// One beat per cycle, unless a held output beat stalls the pipeline.
// Two normalizers, each 68 stages: a 31-stage square root and a 31-stage
// restoring divider, set the depth.
// rst clears every valid bit; payload registers are not reset.
// A held output beat freezes the whole pipeline; nothing is dropped.
module lookat_view_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // side_x/y/z, trueup_x/y/z, back_x/y/z, shift_x/y/z, one zero pad bit
  output logic [375:0] m_tdata
);

  localparam int NL = lav_pkg::NORM_LAT;
  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};

  logic en;
  logic v_a, v_b, v_n1, v_c, v_d, v_n2, v_e, v_f, v_g, v_h, v_i, v_j;

  logic [2:0][31:0] e_a, t_a, u_a;
  logic [2:0][32:0] d_b;
  logic [2:0][31:0] e_b, u_b;
  logic [2:0][30:0] f_n1;
  logic [2:0][31:0] e_n1, u_n1;
  logic [2:0][62:0] pa_c, pb_c;
  logic [2:0][30:0] f_c, f_d;
  logic [2:0][31:0] e_c, e_d;
  logic [2:0][63:0] r_d;
  logic [2:0][30:0] s_n2, f_n2;
  logic [2:0][31:0] e_n2;
  logic [2:0][61:0] ca_e, cb_e;
  logic [2:0][62:0] ps_e, pf_e;
  logic [2:0][30:0] s_e, f_e, s_f, f_f, s_g, f_g, t_g;
  logic [2:0][31:0] e_e, e_f, e_g;
  logic [2:0][62:0] cd_f;
  logic [64:0]      ds_f, df_f;
  logic [31:0]      shs_g, shf_g, shs_h, shf_h, shs_i, shf_i;
  logic [2:0][62:0] pt_h;
  logic [2:0][30:0] s_h, t_h, f_h, s_i, t_i, f_i;
  logic [64:0]      dt_i;
  logic [2:0][30:0] sd_j, tu_j, bk_j;
  logic [2:0][31:0] sh_j;

  assign en       = !v_j || m_tready;
  assign s_tready = en;
  assign m_tvalid = v_j;
  assign m_tdata  = {1'b0, sh_j, bk_j, tu_j, sd_j};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
      v_h <= 1'b0;
      v_i <= 1'b0;
      v_j <= 1'b0;
    end else if (en) begin
      v_a <= s_tvalid;
      v_b <= v_a;
      v_c <= v_n1;
      v_d <= v_c;
      v_e <= v_n2;
      v_f <= v_e;
      v_g <= v_f;
      v_h <= v_g;
      v_i <= v_h;
      v_j <= v_i;
    end
  end

  lav_norm #(.CW(33)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_b),
    .vec      (d_b),
    .out_valid(v_n1),
    .unit     (f_n1)
  );

  lav_delay #(.W(192), .D(NL)) u_dly_fwd (
    .clk(clk),
    .en (en),
    .d  ({e_b, u_b}),
    .q  ({e_n1, u_n1})
  );

  lav_norm #(.CW(64)) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v_d),
    .vec      (r_d),
    .out_valid(v_n2),
    .unit     (s_n2)
  );

  lav_delay #(.W(189), .D(NL)) u_dly_side (
    .clk(clk),
    .en (en),
    .d  ({f_d, e_d}),
    .q  ({f_n2, e_n2})
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_a[i] <= s_tdata[32*i +: 32];
        t_a[i] <= s_tdata[96 + 32*i +: 32];
        u_a[i] <= s_tdata[192 + 32*i +: 32];

        d_b[i] <= $signed(t_a[i]) - $signed(e_a[i]);

        pa_c[i] <= $signed(f_n1[NX[i]]) * $signed(u_n1[NY[i]]);
        pb_c[i] <= $signed(f_n1[NY[i]]) * $signed(u_n1[NX[i]]);

        r_d[i] <= $signed(pa_c[i]) - $signed(pb_c[i]);

        ca_e[i] <= $signed(s_n2[NX[i]]) * $signed(f_n2[NY[i]]);
        cb_e[i] <= $signed(s_n2[NY[i]]) * $signed(f_n2[NX[i]]);
        ps_e[i] <= $signed(s_n2[i]) * $signed(e_n2[i]);
        pf_e[i] <= $signed(f_n2[i]) * $signed(e_n2[i]);

        cd_f[i] <= $signed(ca_e[i]) - $signed(cb_e[i]);

        t_g[i] <= lav_pkg::sat31(lav_pkg::round30($signed(cd_f[i])));

        pt_h[i] <= $signed(t_g[i]) * $signed(e_g[i]);

        bk_j[i] <= (f_i[i] == {1'b1, 30'd0}) ? {1'b0, {30{1'b1}}} : -f_i[i];
      end
      e_b <= e_a;
      u_b <= u_a;
      f_c <= f_n1;
      e_c <= e_n1;
      f_d <= f_c;
      e_d <= e_c;
      s_e <= s_n2;
      f_e <= f_n2;
      e_e <= e_n2;

      ds_f <= $signed(ps_e[0]) + $signed(ps_e[1]) + $signed(ps_e[2]);
      df_f <= $signed(pf_e[0]) + $signed(pf_e[1]) + $signed(pf_e[2]);
      s_f  <= s_e;
      f_f  <= f_e;
      e_f  <= e_e;

      shs_g <= lav_pkg::sat32(-lav_pkg::round30($signed(ds_f)));
      shf_g <= lav_pkg::sat32(lav_pkg::round30($signed(df_f)));
      s_g   <= s_f;
      f_g   <= f_f;
      e_g   <= e_f;

      s_h   <= s_g;
      t_h   <= t_g;
      f_h   <= f_g;
      shs_h <= shs_g;
      shf_h <= shf_g;

      dt_i  <= $signed(pt_h[0]) + $signed(pt_h[1]) + $signed(pt_h[2]);
      s_i   <= s_h;
      t_i   <= t_h;
      f_i   <= f_h;
      shs_i <= shs_h;
      shf_i <= shf_h;

      sd_j     <= s_i;
      tu_j     <= t_i;
      sh_j[0]  <= shs_i;
      sh_j[1]  <= lav_pkg::sat32(-lav_pkg::round30($signed(dt_i)));
      sh_j[2]  <= shf_i;
    end
  end

endmodule

[hdl/lav_chk.sv]
module lav_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [287:0] s_tdata,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [375:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_side0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[92:0] == 93'd0 |-> m_tdata[185:93] == 93'd0)
    else $error("zero side with nonzero up");

  a_back0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[278:186] == 93'd0 |-> m_tdata[92:0] == 93'd0
      && m_tdata[374:343] == 32'd0)
    else $error("zero forward with nonzero side or translation");

endmodule

bind lookat_view_matrix_top lav_chk u_chk (.*);

[tb/lookat_view_matrix_top_test.sv]
`timescale 1ns / 1ps

module lookat_view_matrix_top_test;

  localparam int UNIT_BITS = 30;
  localparam longint UMAX = 64'sd1073741823;
  localparam longint UMIN = -64'sd1073741824;
  localparam int LATENCY = 146;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] sh_z, sh_y, sh_x;
    logic [30:0] bk_z, bk_y, bk_x;
    logic [30:0] up_z, up_y, up_x;
    logic [30:0] sd_z, sd_y, sd_x;
  } view_rows_t;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_off(longint v, int sh);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input longint c[3], output longint u[3]);
    longint unsigned m[3], top, n, r, q;
    for (int i = 0; i < 3; i++) m[i] = c[i] < 0 ? -c[i] : c[i];
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (top >= (64'd1 << UNIT_BITS)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << (UNIT_BITS - 1))) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    n = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = root_floor(n);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << UNIT_BITS) + (r >> 1)) / r;
      u[i] = sat(c[i] < 0 ? -longint'(q) : longint'(q), UMIN, UMAX);
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint shift_of(longint row[3], longint eye[3], bit neg);
    longint d;
    d = row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2];
    if (neg) d = -d;
    return sat(round_off(d, UNIT_BITS), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic view_rows_t view_of(logic [287:0] d);
    longint eye[3], tgt[3], upw[3], diff[3], fwd[3], rs[3], sd[3], pr[3], tu[3], bk[3];
    view_rows_t v;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(d[32*i +: 32]));
      tgt[i] = longint'($signed(d[32*(3+i) +: 32]));
      upw[i] = longint'($signed(d[32*(6+i) +: 32]));
      diff[i] = tgt[i] - eye[i];
    end
    unit_vec(diff, fwd);
    cross3(fwd, upw, rs);
    unit_vec(rs, sd);
    cross3(sd, fwd, pr);
    for (int i = 0; i < 3; i++) begin
      tu[i] = sat(round_off(pr[i], UNIT_BITS), UMIN, UMAX);
      bk[i] = sat(-fwd[i], UMIN, UMAX);
    end
    v.sd_x = 31'(sd[0]); v.sd_y = 31'(sd[1]); v.sd_z = 31'(sd[2]);
    v.up_x = 31'(tu[0]); v.up_y = 31'(tu[1]); v.up_z = 31'(tu[2]);
    v.bk_x = 31'(bk[0]); v.bk_y = 31'(bk[1]); v.bk_z = 31'(bk[2]);
    v.sh_x = 32'(shift_of(sd, eye, 1));
    v.sh_y = 32'(shift_of(tu, eye, 1));
    v.sh_z = 32'(shift_of(fwd, eye, 0));
    return v;
  endfunction

  class view_scoreboard;
    view_rows_t pending[$];
    int errors = 0;
    int seen = 0;

    function void note(logic [287:0] d);
      pending.push_back(view_of(d));
    endfunction

    function void check(view_rows_t got);
      view_rows_t w;
      seen++;
      if (pending.size() == 0) begin
        $display("%t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.sd_x !== got.sd_x) report("side_x", w.sd_x, got.sd_x);
      if (w.sd_y !== got.sd_y) report("side_y", w.sd_y, got.sd_y);
      if (w.sd_z !== got.sd_z) report("side_z", w.sd_z, got.sd_z);
      if (w.up_x !== got.up_x) report("trueup_x", w.up_x, got.up_x);
      if (w.up_y !== got.up_y) report("trueup_y", w.up_y, got.up_y);
      if (w.up_z !== got.up_z) report("trueup_z", w.up_z, got.up_z);
      if (w.bk_x !== got.bk_x) report("back_x", w.bk_x, got.bk_x);
      if (w.bk_y !== got.bk_y) report("back_y", w.bk_y, got.bk_y);
      if (w.bk_z !== got.bk_z) report("back_z", w.bk_z, got.bk_z);
      if (w.sh_x !== got.sh_x) report("shift_x", w.sh_x, got.sh_x);
      if (w.sh_y !== got.sh_y) report("shift_y", w.sh_y, got.sh_y);
      if (w.sh_z !== got.sh_z) report("shift_z", w.sh_z, got.sh_z);
    endfunction

    function void report(string f, logic [31:0] w, logic [31:0] g);
      $display("%t: %s expected %h actual %h", $time, f, w, g);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [375:0] m_tdata;

  view_scoreboard board = new();
  bit calm = 0;
  bit hold_off = 0;
  int cycles = 0;

  lookat_view_matrix_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("lookat_view_matrix_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check(view_rows_t'(m_tdata[374:0]));
  end

  int burst = 0;
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_tready <= 0;
    end else if (burst > 0) begin
      burst <= burst - 1;
      m_tready <= 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      burst <= $urandom_range(0, 7);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  task automatic send(logic [287:0] d);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 511) - 256;
      3: return ($urandom_range(0, 65535) - 32768) << 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [287:0] pack9(logic [31:0] a[9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = a[i];
    return d;
  endfunction

  task automatic send9(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    logic [31:0] a[9];
    a = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    send(pack9(a));
  endtask

  initial begin
    logic [31:0] a[9];
    logic [31:0] mn, mx, one;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    one = 32'h0001_0000;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send9(0, 0, 0, 0, 0, -one, 0, one, 0);
    send9(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0);
    send9(0, 0, 0, one, 0, 0, one, 0, 0);
    send9(0, 0, 0, 0, 0, one, 0, 0, 0);
    send9(mx, mx, mx, mn, mn, mn, 0, one, 0);
    send9(mn, mn, mn, mx, mx, mx, mx, mn, mx);
    send9(mn, 0, 0, mx, 0, 0, 0, mx, 0);
    send9(mx, mn, mx, 0, 0, 0, mn, mn, mn);
    send9(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send9(0, 0, 0, 1, 1, 1, 0, 0, 1);
    send9(mx, mx, mx, mx, mx, 32'h7fff_fffe, 1, 0, 0);
    send9(one, one, one, -one, -one, -one, one, one, one);
    send9(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0, mn, 0);
    send9(mn, mx, mn, mx, mn, mx, mx, mx, mn);
    send9(32'haaaa_aaaa, 32'h5555_5555, 0, 32'h5555_5555, 32'haaaa_aaaa, 1, 0, 0, 1);

    // fill the pipeline while the output side holds off
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 200; k++) begin
        for (int i = 0; i < 9; i++) a[i] = pick();
        if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) a[3 + i] = a[i];
        if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) a[6 + i] = a[3 + i] - a[i];
        send(pack9(a));
      end
    join

    for (int k = 0; k < 200; k++) begin
      if (k == 150) calm = 1;
      for (int i = 0; i < 9; i++) a[i] = pick();
      if ($urandom_range(0, 15) == 0) for (int i = 6; i < 9; i++) a[i] = 0;
      send(pack9(a));
    end
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d camera setups (directed extremes, degenerate and saturating cases,",
             board.seen);
    $display("random Q16.16 vectors) with random stalls and a long output hold-off.");
    if (board.errors == 0) begin
      $display("lookat_view_matrix_top_test: clean");
    end else begin
      $display("lookat_view_matrix_top_test: errors");
    end
    $finish;
  end

endmodule

[lookat_view_matrix_top.f]
hdl/lav_pkg.sv
hdl/lav_delay.sv
hdl/lav_norm.sv
hdl/lookat_view_matrix_top.sv
hdl/lav_chk.sv
tb/lookat_view_matrix_top_test.sv
